FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/psr_pkg.sv
`default_nettype none

package psr_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned RSSI_W  = 8;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned FRAC_W  = 8;

  // Dividend is |sum| scaled by 2^FRAC_W; it splits into CNT_W remainder bits
  // and MEAN_W quotient bits.
  localparam int unsigned NUM_W     = SUM_W + FRAC_W;
  localparam int unsigned DIV_STEPS = MEAN_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] REPORT_EVERY_RST = CNT_W'(10);
  localparam logic [CNT_W-1:0] CNT_MAX          = '1;

  // Lookup token that walks the cell chain.
  typedef struct packed {
    logic                    act;
    logic [ADDR_W-1:0]       addr;
    logic                    found;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic                    free;
  } psr_tok_t;

  // Update broadcast to all cells once the lookup is done.
  typedef struct packed {
    logic                    we;
    logic                    claim;
    logic [ADDR_W-1:0]       addr;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } psr_cmt_t;

endpackage

`default_nettype wire

FILE: rtl/core/psr_cell.sv
`default_nettype none

module psr_cell
  import psr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  psr_tok_t tok_i,
  output psr_tok_t tok_o,
  input  psr_cmt_t cmt_i
);

  logic                    valid_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    sel_hit_q, sel_hit_d;
  logic                    sel_free_q, sel_free_d;
  psr_tok_t                tok_q, tok_d;
  logic                    hit;
  logic                    wr;

  // Only the first matching entry along the chain takes the hit.
  assign hit = valid_q && (addr_q == tok_i.addr) && !tok_i.found;
  assign wr  = cmt_i.we && (cmt_i.claim ? sel_free_q : sel_hit_q);

  always_comb begin
    tok_d      = tok_i;
    sel_hit_d  = sel_hit_q;
    sel_free_d = sel_free_q;
    if (tok_i.act) begin
      sel_hit_d  = hit;
      sel_free_d = !valid_q && !tok_i.free;
      if (hit) begin
        tok_d.found = 1'b1;
        tok_d.sum   = sum_q;
        tok_d.cnt   = cnt_q;
      end
      if (!valid_q) begin
        tok_d.free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      cnt_q      <= '0;
      sum_q      <= '0;
      sel_hit_q  <= 1'b0;
      sel_free_q <= 1'b0;
      tok_q      <= '0;
    end else begin
      sel_hit_q  <= sel_hit_d;
      sel_free_q <= sel_free_d;
      tok_q      <= tok_d;
      if (wr) begin
        valid_q <= 1'b1;
        cnt_q   <= cmt_i.cnt;
        sum_q   <= cmt_i.sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr && cmt_i.claim) begin
      addr_q <= cmt_i.addr;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: rtl/core/psr_div.sv
`default_nettype none

module psr_div
  import psr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]         cnt_i,
  output logic                     done_o,
  output logic signed [MEAN_W-1:0] mean_o
);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic                neg_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [MEAN_W-1:0]   quo_q, quo_d;
  logic [SUM_W-1:0]    mag;
  logic [NUM_W-1:0]    num;
  logic [CNT_W:0]      cur;
  logic [CNT_W:0]      diff;
  logic                ge;
  logic                last;

  // Rounding to nearest is folded into the dividend as half the divisor.
  assign mag  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign num  = {mag, FRAC_W'(0)} + NUM_W'(cnt_i[CNT_W-1:1]);

  assign cur  = {rem_q, quo_q[MEAN_W-1]};
  assign diff = cur - {1'b0, cnt_q};
  assign ge   = cur >= {1'b0, cnt_q};
  assign last = step_q == STEP_W'(DIV_STEPS - 1);

  always_comb begin
    rem_d = ge ? diff[CNT_W-1:0] : cur[CNT_W-1:0];
    quo_d = {quo_q[MEAN_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient never exceeds 2^15, so the top remainder bits start below
  // the divisor and MEAN_W steps are enough.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q <= sum_i[SUM_W-1];
      cnt_q <= cnt_i;
      rem_q <= num[NUM_W-1 -: CNT_W];
      quo_q <= num[MEAN_W-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign mean_o = neg_q ? MEAN_W'(-quo_q) : MEAN_W'(quo_q);

endmodule

`default_nettype wire

FILE: rtl/core/per_source_rssi_mean_reporter.sv
// Per-source RSSI mean reporter. Each input word is one ping (source address
// and signed dBm value); each produces exactly one output word. The address is
// looked up in a table of TABLE_ENTRIES entries held in a chain of cells that
// a lookup token walks one cell per clock; a new address claims the first
// free entry, and with no free entry the word comes back with dropped set.
// When an entry has gathered report_every samples, the output carries the
// address and the mean in signed Q7.8, rounded to nearest with ties away from
// zero, and the entry restarts. One word is in flight at a time: a ping walks
// the cell chain, runs the 16-step serial divider if it completes a report,
// then waits until the output register can take it. The finished word sits
// there, so the next ping goes in while it waits. The user writes report_every
// through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
`default_nettype none

module per_source_rssi_mean_reporter
  import psr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ADDR_W-1:0]        src_addr_i,
  input  logic signed [RSSI_W-1:0] rssi_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     report_ready_o,
  output logic [ADDR_W-1:0]        report_addr_o,
  output logic signed [MEAN_W-1:0] mean_rssi_o,
  output logic                     dropped_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } psr_state_e;

  psr_state_e               state_q, state_d;
  logic [CNT_W-1:0]         report_every_q;
  logic [ADDR_W-1:0]        addr_q;
  logic signed [RSSI_W-1:0] rssi_q;
  logic                     res_rep_q, res_rep_d;
  logic                     res_drop_q, res_drop_d;
  logic signed [MEAN_W-1:0] res_mean_q, res_mean_d;
  logic                     out_valid_q;
  logic                     out_rep_q;
  logic                     out_drop_q;
  logic [ADDR_W-1:0]        out_addr_q;
  logic signed [MEAN_W-1:0] out_mean_q;

  psr_tok_t                 chain [TABLE_ENTRIES+1];
  psr_tok_t                 tok_end;
  psr_cmt_t                 cmt;
  logic                     in_acc;
  logic                     out_load;
  logic signed [SUM_W-1:0]  base_sum;
  logic [CNT_W-1:0]         base_cnt;
  logic signed [SUM_W-1:0]  new_sum;
  logic [CNT_W-1:0]         new_cnt;
  logic                     report;
  logic                     div_start;
  logic                     div_done;
  logic signed [MEAN_W-1:0] div_mean;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    chain[0]       = '0;
    chain[0].act   = in_acc;
    chain[0].addr  = src_addr_i;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    psr_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1]),
      .cmt_i (cmt)
    );
  end

  assign tok_end = chain[TABLE_ENTRIES];

  // A new entry starts from an empty sum and count.
  assign base_sum = tok_end.found ? tok_end.sum : '0;
  assign base_cnt = tok_end.found ? tok_end.cnt : '0;
  assign new_sum  = base_sum + SUM_W'(rssi_q);
  assign new_cnt  = (base_cnt == CNT_MAX) ? CNT_MAX : base_cnt + CNT_W'(1);
  assign report   = new_cnt >= report_every_q;

  always_comb begin
    cmt.we    = (state_q == S_SCAN) && tok_end.act && (tok_end.found || tok_end.free);
    cmt.claim = !tok_end.found;
    cmt.addr  = addr_q;
    cmt.sum   = report ? '0 : new_sum;
    cmt.cnt   = report ? '0 : new_cnt;
  end

  assign div_start = cmt.we && report;

  psr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (new_sum),
    .cnt_i  (new_cnt),
    .done_o (div_done),
    .mean_o (div_mean)
  );

  always_comb begin
    state_d    = state_q;
    res_rep_d  = res_rep_q;
    res_drop_d = res_drop_q;
    res_mean_d = res_mean_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_end.act) begin
          res_rep_d  = 1'b0;
          res_drop_d = !(tok_end.found || tok_end.free);
          res_mean_d = '0;
          state_d    = div_start ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_rep_d  = 1'b1;
          res_mean_d = div_mean;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      report_every_q <= REPORT_EVERY_RST;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        report_every_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_rep_q  <= res_rep_d;
    res_drop_q <= res_drop_d;
    res_mean_q <= res_mean_d;
    if (in_acc) begin
      addr_q <= src_addr_i;
      rssi_q <= rssi_i;
    end
    if (out_load) begin
      out_rep_q  <= res_rep_q;
      out_drop_q <= res_drop_q;
      out_addr_q <= res_rep_q ? addr_q : '0;
      out_mean_q <= res_mean_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_ready_o = out_rep_q;
  assign dropped_o      = out_drop_q;
  assign report_addr_o  = out_addr_q;
  assign mean_rssi_o    = out_mean_q;

endmodule

`default_nettype wire

FILE: rtl/core/psr_chk.sv
`default_nettype none
`include "assert_macros.svh"

module psr_chk
  import psr_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic [CNT_W-1:0]         cfg_wdata_i,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [ADDR_W-1:0]        src_addr_i,
  input logic signed [RSSI_W-1:0] rssi_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     report_ready_o,
  input logic [ADDR_W-1:0]        report_addr_o,
  input logic signed [MEAN_W-1:0] mean_rssi_o,
  input logic                     dropped_o
);

  logic in_acc;
  logic out_hold;
  logic cfg_seen;
  logic src_seen;
  logic rssi_seen;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_hold  = out_valid_o && !out_ready_i;
  // Inputs that only the environment drives carry no property of their own.
  assign cfg_seen  = cfg_we_i || (cfg_wdata_i != '0);
  assign src_seen  = src_addr_i != '0;
  assign rssi_seen = rssi_i != '0;

  // A waiting word keeps its contents until taken.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(mean_rssi_o) && $stable(report_addr_o))
  // A dropped ping never carries a report.
  `ASSERT_IMP(a_drop_no_rep, clk_i, rst_ni, out_valid_o && dropped_o, !report_ready_o)
  // Without a report, address and mean read as zero.
  `ASSERT_IMP(a_idle_fields, clk_i, rst_ni, out_valid_o && !report_ready_o, (report_addr_o == '0) && (mean_rssi_o == '0))
  // Pings are taken one at a time: the lookup needs the whole chain.
  `ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_acc || (cfg_seen && src_seen && rssi_seen && in_acc), !in_ready_o)

endmodule

bind per_source_rssi_mean_reporter psr_chk u_psr_chk (.*);

`default_nettype wire

FILE: tb/tb_per_source_rssi_mean_reporter.sv
module tb_per_source_rssi_mean_reporter;
  timeunit 1ns;
  timeprecision 1ps;

  import psr_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic                     report_ready;
    logic [ADDR_W-1:0]        report_addr;
    logic signed [MEAN_W-1:0] mean;
    logic                     dropped;
  } ping_report_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CNT_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ADDR_W-1:0]        src_addr_i;
  logic signed [RSSI_W-1:0] rssi_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     report_ready_o;
  logic [ADDR_W-1:0]        report_addr_o;
  logic signed [MEAN_W-1:0] mean_rssi_o;
  logic                     dropped_o;

  per_source_rssi_mean_reporter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_addr_i     (src_addr_i),
    .rssi_i         (rssi_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_ready_o (report_ready_o),
    .report_addr_o  (report_addr_o),
    .mean_rssi_o    (mean_rssi_o),
    .dropped_o      (dropped_o)
  );

  // Shadow of the source table, starting from its reset contents.
  logic                 src_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [ADDR_W-1:0]    src_addr  [TABLE_ENTRIES] = '{default: '0};
  logic [CNT_W-1:0]     src_count [TABLE_ENTRIES] = '{default: '0};
  int                   src_sum   [TABLE_ENTRIES] = '{default: 0};
  logic [CNT_W-1:0]     pings_per_report = REPORT_EVERY_RST;

  // Entries are never released, so these eight sources own the table for good
  // once they have been seen; any other address is dropped from then on.
  logic [ADDR_W-1:0] known_src [8] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE,
                                       16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0};

  ping_report_t expected_reports [$];
  int           err_count     = 0;
  int           cycle_count   = 0;
  bit           idle_on       = 1'b1;
  int           sink_hold_req = 0;

  function automatic ping_report_t predict_ping(input logic [ADDR_W-1:0] addr,
                                                input logic signed [RSSI_W-1:0] rssi);
    ping_report_t res;
    int           hit;
    int           spare;
    longint       num;
    longint       mag;
    longint       quo;
    res   = '{default: '0};
    hit   = -1;
    spare = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (src_valid[i]) begin
        if (hit < 0 && src_addr[i] == addr) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0 && spare < 0) begin
      res.dropped = 1'b1;
    end else begin
      if (hit < 0) begin
        hit            = spare;
        src_valid[hit] = 1'b1;
        src_addr[hit]  = addr;
        src_count[hit] = '0;
        src_sum[hit]   = 0;
      end
      src_sum[hit] += int'(rssi);
      if (src_count[hit] != CNT_MAX) src_count[hit] += 1'b1;
      if (src_count[hit] >= pings_per_report) begin
        // Q7.8 mean, rounded half away from zero on the magnitude.
        num = longint'(src_sum[hit]) * 256;
        mag = (num < 0) ? -num : num;
        quo = (mag + longint'(src_count[hit]) / 2) / longint'(src_count[hit]);
        res.report_ready = 1'b1;
        res.report_addr  = addr;
        res.mean         = MEAN_W'((num < 0) ? -quo : quo);
        src_count[hit]   = '0;
        src_sum[hit]     = 0;
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_stranger();
    logic [ADDR_W-1:0] a;
    bit                clash;
    do begin
      a     = ADDR_W'($urandom);
      clash = 1'b0;
      foreach (known_src[k]) if (known_src[k] == a) clash = 1'b1;
    end while (clash);
    return a;
  endfunction

  function automatic logic signed [RSSI_W-1:0] pick_rssi();
    case ($urandom_range(0, 9))
      0:       return -8'sd128;
      1:       return 8'sd127;
      2:       return 8'sd0;
      3:       return -8'sd1;
      default: return RSSI_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_ping(input logic [ADDR_W-1:0] addr,
                           input logic signed [RSSI_W-1:0] rssi);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    src_addr_i <= addr;
    rssi_i     <= rssi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_reports.push_back(predict_ping(addr, rssi));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  task automatic write_report_every(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    pings_per_report = value;
  endtask

  // Reset value of report_every; source 1 is left part way through a count.
  task automatic test_first_report();
    for (int i = 0; i < 10; i++) begin
      send_ping(known_src[0], 8'sd127);
      if (i < 5) send_ping(known_src[1], -8'sd128);
    end
  endtask

  task automatic test_table_full();
    for (int i = 2; i < 8; i++) send_ping(known_src[i], (i % 2) ? -8'sd128 : 8'sd127);
    send_ping(16'h1234, 8'sd5);
    send_ping(pick_stranger(), -8'sd128);
    send_ping(pick_stranger(), 8'sd127);
  endtask

  // Lowering the threshold under a running count reports on the next ping.
  task automatic test_lowered_threshold();
    write_report_every(11'd2);
    send_ping(known_src[1], 8'sd0);
    send_ping(known_src[0], -8'sd1);
  endtask

  task automatic test_report_every_zero();
    logic signed [RSSI_W-1:0] levels [8] = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1,
                                            8'sd1, -8'sd2, 8'sd64, -8'sd64};
    write_report_every('0);
    for (int i = 0; i < 8; i++) send_ping(known_src[i], levels[i]);
    send_ping(pick_stranger(), 8'sd3);
  endtask

  task automatic test_backpressure();
    write_report_every(11'd3);
    sink_hold_req = 400;
    repeat (12) send_ping(known_src[$urandom_range(0, 7)], pick_rssi());
  endtask

  task automatic test_random_pings(input int count, input logic [CNT_W-1:0] every);
    logic [ADDR_W-1:0] addr;
    write_report_every(every);
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) addr = known_src[$urandom_range(0, 7)];
      else addr = ADDR_W'($urandom);
      send_ping(addr, pick_rssi());
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d words outstanding", $time,
               expected_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side stalls in bursts, or holds off for a long stretch on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (sink_hold_req > 0) begin
        out_ready_i <= 1'b0;
        repeat (sink_hold_req) @(posedge clk_i);
        sink_hold_req = 0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (idle_on ? $urandom_range(1, 12) : 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    ping_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("word with no ping pending, addr", report_addr_o, 0);
      end else begin
        want = expected_reports.pop_front();
        if (report_ready_o !== want.report_ready)
          report_mismatch("report_ready", report_ready_o, want.report_ready);
        if (report_addr_o !== want.report_addr)
          report_mismatch("report_addr", report_addr_o, want.report_addr);
        if (mean_rssi_o !== want.mean)
          report_mismatch("mean_rssi", mean_rssi_o, want.mean);
        if (dropped_o !== want.dropped)
          report_mismatch("dropped", dropped_o, want.dropped);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    src_addr_i  = '0;
    rssi_i      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_report();
    test_table_full();
    test_lowered_threshold();
    test_report_every_zero();
    test_backpressure();
    test_random_pings(150, 11'd1);
    test_random_pings(100, CNT_W'($urandom_range(2, 12)));
    test_random_pings(100, 11'd5);
    idle_on = 1'b0;
    test_random_pings(100, 11'd4);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
